@@ src/tcw_pkg.sv @@
// Shared constants, types and codes for the text console writer
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int CELL_COUNT   = COLUMNS * ROWS;
    localparam int SCROLL_CELLS = (ROWS - 1) * COLUMNS;

    localparam int OPCODE_W = 2;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 8;
    localparam int INDEX_W  = 11;
    localparam int POS_W    = 11;
    localparam int CELL_W   = CHAR_W + COLOR_W;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CNT_W  = $clog2(CELL_COUNT + 1);
    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
    localparam logic [COLOR_W-1:0] WHITE_ATTR   = 8'd15;
    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
    localparam logic [CELL_W-1:0]  BLANK_CELL   = {WHITE_ATTR, BLANK_CHAR};

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_SPARE = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        CMD_PUT,
        CMD_NEWLINE,
        CMD_CLEAR,
        CMD_READ,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [CHAR_W-1:0]  ch;
        logic [COLOR_W-1:0] color;
        logic [ADDR_W-1:0]  addr;
    } cmd_t;

endpackage

`default_nettype wire

@@ src/tcw_in_if.sv @@
// Request channel: operation beats into the console
`default_nettype none

interface tcw_in_if import tcw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [CHAR_W-1:0]   char_code;
    logic [COLOR_W-1:0]  color;
    logic [INDEX_W-1:0]  cell_index;

    modport source (output valid, output opcode, output char_code, output color,
                    output cell_index, input ready);
    modport sink   (input valid, input opcode, input char_code, input color,
                    input cell_index, output ready);
endinterface

`default_nettype wire

@@ src/tcw_out_if.sv @@
// Response channel: cursor position and read cell beats out of the console
`default_nettype none

interface tcw_out_if import tcw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [POS_W-1:0]   cursor_pos;
    logic [CHAR_W-1:0]  read_char;
    logic [COLOR_W-1:0] read_color;

    modport source (output valid, output cursor_pos, output read_char,
                    output read_color, input ready);
    modport sink   (input valid, input cursor_pos, input read_char,
                    input read_color, output ready);
endinterface

`default_nettype wire

@@ src/tcw_front.sv @@
// Front end: takes request beats and decodes them into back-end commands
`default_nettype none

module tcw_front import tcw_pkg::*; (
    tcw_in_if.sink request,
    input  logic   enable,
    output cmd_t   cmd,
    output logic   cmd_valid,
    input  logic   cmd_ready
);

    logic in_range;

    assign in_range      = 32'(request.cell_index) < CELL_COUNT;
    assign request.ready = cmd_ready && enable;
    assign cmd_valid     = request.valid && enable;

    always_comb
    begin
        cmd.ch    = request.char_code;
        cmd.color = request.color;
        cmd.addr  = ADDR_W'(request.cell_index);
        unique case (opcode_t'(request.opcode))
            OP_PUT:
            begin
                cmd.kind = (request.char_code == NEWLINE_CODE) ? CMD_NEWLINE : CMD_PUT;
            end
            OP_CLEAR: cmd.kind = CMD_CLEAR;
            OP_READ:
            begin
                cmd.kind = in_range ? CMD_READ : CMD_NOP;
            end
            OP_SPARE: cmd.kind = CMD_NOP;
        endcase
    end

endmodule

`default_nettype wire

@@ src/tcw_queue.sv @@
// Short command queue between the front and back ends
`default_nettype none

module tcw_queue import tcw_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  cmd_t push_data,
    input  logic push_valid,
    output logic push_ready,
    output cmd_t pop_data,
    output logic pop_valid,
    input  logic pop
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/tcw_back.sv @@
// Back end: cursor, screen store, scroll and clear sweeps, response register
`default_nettype none

module tcw_back import tcw_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  logic cmd_valid,
    output logic cmd_pop,
    output logic init_done,
    tcw_out_if.source response
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_COPY,
        S_FILL
    } state_t;

    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] SCROLL_POS = ADDR_W'(SCROLL_CELLS);
    localparam logic [CNT_W-1:0]  COPY_END   = CNT_W'(SCROLL_CELLS);
    localparam logic [CNT_W-1:0]  FILL_END   = CNT_W'(CELL_COUNT - 1);

    logic [CELL_W-1:0]  screen_mem [CELL_COUNT];
    logic [CELL_W-1:0]  rd_data_reg;

    state_t             state_reg;
    logic [CNT_W-1:0]   ptr_reg;
    logic               fill_report_reg;
    logic               init_done_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [ADDR_W-1:0]  pos_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic [COLOR_W-1:0] out_color_reg;

    logic               slot_free;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;

    assign slot_free           = !out_valid_reg || response.ready;
    assign cmd_pop             = (state_reg == S_IDLE) && cmd_valid && slot_free;
    assign init_done           = init_done_reg;
    assign response.valid      = out_valid_reg;
    assign response.cursor_pos = POS_W'(pos_reg);
    assign response.read_char  = out_char_reg;
    assign response.read_color = out_color_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pos_reg;
        mem_wdata = BLANK_CELL;
        mem_raddr = cmd.addr;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_pop && cmd.kind == CMD_PUT)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {cmd.color, cmd.ch};
                end
            end
            S_READ: ;
            S_COPY:
            begin
                // read one row ahead, write the cell fetched last cycle
                mem_raddr = ADDR_W'(ptr_reg) + ADDR_W'(COLUMNS);
                if (ptr_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ADDR_W'(ptr_reg - 1'b1);
                    mem_wdata = rd_data_reg;
                end
            end
            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(ptr_reg);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= screen_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_FILL;
            ptr_reg         <= '0;
            fill_report_reg <= 1'b0;
            init_done_reg   <= 1'b0;
            col_reg         <= '0;
            row_reg         <= '0;
            pos_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_char_reg    <= '0;
            out_color_reg   <= '0;
        end
        else
        begin
            if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_pop)
                    begin
                        out_char_reg  <= '0;
                        out_color_reg <= '0;
                        unique case (cmd.kind)
                            CMD_PUT, CMD_NEWLINE:
                            begin
                                if (cmd.kind == CMD_PUT && col_reg != COL_LAST)
                                begin
                                    col_reg       <= col_reg + 1'b1;
                                    pos_reg       <= pos_reg + 1'b1;
                                    out_valid_reg <= 1'b1;
                                end
                                else if (row_reg == ROW_LAST)
                                begin
                                    col_reg   <= '0;
                                    pos_reg   <= SCROLL_POS;
                                    ptr_reg   <= '0;
                                    state_reg <= S_COPY;
                                end
                                else
                                begin
                                    col_reg       <= '0;
                                    row_reg       <= row_reg + 1'b1;
                                    pos_reg       <= pos_reg - ADDR_W'(col_reg)
                                                     + ADDR_W'(COLUMNS);
                                    out_valid_reg <= 1'b1;
                                end
                            end
                            CMD_CLEAR:
                            begin
                                col_reg         <= '0;
                                row_reg         <= '0;
                                pos_reg         <= '0;
                                ptr_reg         <= '0;
                                fill_report_reg <= 1'b1;
                                state_reg       <= S_FILL;
                            end
                            CMD_READ: state_reg <= S_READ;
                            default: out_valid_reg <= 1'b1;
                        endcase
                    end
                end
                S_READ:
                begin
                    out_valid_reg <= 1'b1;
                    out_char_reg  <= rd_data_reg[CHAR_W-1:0];
                    out_color_reg <= rd_data_reg[CELL_W-1:CHAR_W];
                    state_reg     <= S_IDLE;
                end
                S_COPY:
                begin
                    if (ptr_reg == COPY_END)
                    begin
                        fill_report_reg <= 1'b1;
                        state_reg       <= S_FILL;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                S_FILL:
                begin
                    if (ptr_reg == FILL_END)
                    begin
                        init_done_reg   <= 1'b1;
                        fill_report_reg <= 1'b0;
                        state_reg       <= S_IDLE;
                        if (fill_report_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            out_char_reg  <= '0;
                            out_color_reg <= '0;
                        end
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
            endcase
        end
    end

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < COLUMNS)
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(row_reg) < ROWS)
        else $error("cursor row out of range");

    a_pos_track: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) == 32'(row_reg) * COLUMNS + 32'(col_reg))
        else $error("linear cursor position out of step with row and column");

    a_busy_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !out_valid_reg)
        else $error("response beat pending during a multi-cycle operation");

    a_read_beat: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> out_valid_reg && state_reg == S_IDLE)
        else $error("cell read did not produce a response beat");

endmodule

`default_nettype wire

@@ src/text_console_writer.sv @@
// Top level of the text console writer
//
// Character-cell console of COLUMNS x ROWS cells (80 x 25), one request beat in and one
// response beat out per operation. A put or newline that does not scroll, an unused
// opcode and an out-of-range read are done in the idle state; an in-range read also passes
// through S_READ for the registered read port of the screen store. A clear sweeps all
// COLUMNS*ROWS cells of the store one cell a cycle. A put or newline past the last row
// scrolls: one copy pass moves the lower (ROWS-1)*COLUMNS cells up a row, then a blank
// fill covers the bottom row. After reset the store is blanked by the same sweep, during
// which no request is taken. A two-entry command queue lets requests be taken while
// the back end works; the response stays registered until taken.
`default_nettype none

module text_console_writer import tcw_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    tcw_in_if.sink    request,
    tcw_out_if.source response
);

    cmd_t front_cmd;
    logic front_valid;
    logic front_ready;
    cmd_t back_cmd;
    logic back_valid;
    logic back_pop;
    logic init_done;

    tcw_front u_front (
        .request   (request),
        .enable    (init_done),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    tcw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_data   (back_cmd),
        .pop_valid  (back_valid),
        .pop        (back_pop)
    );

    tcw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_valid (back_valid),
        .cmd_pop   (back_pop),
        .init_done (init_done),
        .response  (response)
    );

endmodule

`default_nettype wire

@@ test/text_console_writer_tb.sv @@
// Testbench for the text console writer: random put, clear and read beats checked against a model
`timescale 1ns / 100ps

module text_console_writer_tb;
    import tcw_pkg::*;

    typedef struct packed {
        opcode_t            op;
        logic [CHAR_W-1:0]  ch;
        logic [COLOR_W-1:0] color;
        logic [INDEX_W-1:0] idx;
    } console_op_t;

    typedef struct packed {
        logic [POS_W-1:0]   cursor_pos;
        logic [CHAR_W-1:0]  read_char;
        logic [COLOR_W-1:0] read_color;
    } console_reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                req_valid = 1'b0;
    logic [OPCODE_W-1:0] req_opcode = '0;
    logic [CHAR_W-1:0]   req_char = '0;
    logic [COLOR_W-1:0]  req_color = '0;
    logic [INDEX_W-1:0]  req_index = '0;
    logic                resp_ready = 1'b0;

    tcw_in_if  request ();
    tcw_out_if response ();

    assign request.valid      = req_valid;
    assign request.opcode     = req_opcode;
    assign request.char_code  = req_char;
    assign request.color      = req_color;
    assign request.cell_index = req_index;
    assign response.ready     = resp_ready;

    text_console_writer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .response (response)
    );

    console_op_t    op_backlog[$];
    console_reply_t expected_replies[$];

    logic [CELL_W-1:0] screen_mirror [CELL_COUNT];
    int cursor_col;
    int cursor_row;

    int src_idle_pct = 33;
    int sink_idle_pct = 83;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_cnt = 0;
    int queued_ops = 0;
    int mismatches = 0;

    function automatic void blank_screen();
        for (int i = 0; i < CELL_COUNT; i++)
            screen_mirror[i] = BLANK_CELL;
    endfunction

    function automatic console_reply_t console_apply(console_op_t r);
        console_reply_t res;
        res = '0;
        case (r.op)
            OP_PUT:
            begin
                if (r.ch == NEWLINE_CODE)
                begin
                    cursor_col = 0;
                    cursor_row++;
                end
                else
                begin
                    screen_mirror[cursor_row * COLUMNS + cursor_col] = {r.color, r.ch};
                    cursor_col++;
                end
                if (cursor_col >= COLUMNS)
                begin
                    cursor_col = 0;
                    cursor_row++;
                end
                if (cursor_row >= ROWS)
                begin
                    for (int i = 0; i < SCROLL_CELLS; i++)
                        screen_mirror[i] = screen_mirror[i + COLUMNS];
                    for (int i = SCROLL_CELLS; i < CELL_COUNT; i++)
                        screen_mirror[i] = BLANK_CELL;
                    cursor_row = ROWS - 1;
                end
            end
            OP_CLEAR:
            begin
                blank_screen();
                cursor_col = 0;
                cursor_row = 0;
            end
            OP_READ:
            begin
                if (r.idx < CELL_COUNT)
                begin
                    res.read_char  = screen_mirror[r.idx][CHAR_W-1:0];
                    res.read_color = screen_mirror[r.idx][CELL_W-1:CHAR_W];
                end
            end
            default: ;
        endcase
        res.cursor_pos = POS_W'(cursor_row * COLUMNS + cursor_col);
        return res;
    endfunction

    task automatic queue_op(opcode_t op, int ch, int color, int idx);
        console_op_t r;
        r.op    = op;
        r.ch    = CHAR_W'(ch);
        r.color = COLOR_W'(color);
        r.idx   = INDEX_W'(idx);
        op_backlog.push_back(r);
        if (op != OP_SPARE)
            queued_ops++;
    endtask

    function automatic int text_byte();
        int b;
        b = $urandom_range(255);
        if (b == NEWLINE_CODE)
            b = 8'h2A;
        return b;
    endfunction

    function automatic int read_index();
        int k;
        k = $urandom_range(99);
        if (k < 40)
            return $urandom_range(CELL_COUNT - 1, SCROLL_CELLS - COLUMNS * 4);
        else if (k < 85)
            return $urandom_range(CELL_COUNT - 1);
        else
            return $urandom_range(2047, CELL_COUNT);
    endfunction

    task automatic queue_line(int n);
        repeat (n)
            queue_op(OP_PUT, text_byte(), $urandom_range(255), $urandom_range(2047));
    endtask

    task automatic queue_random_chunk();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 52)
        begin
            queue_line($urandom_range(6));
            queue_op(OP_PUT, NEWLINE_CODE, $urandom_range(255), $urandom_range(2047));
        end
        else if (kind < 56)
        begin
            queue_line($urandom_range(84, 74));
            if ($urandom_range(1) == 1)
                queue_op(OP_PUT, NEWLINE_CODE, $urandom_range(255), $urandom_range(2047));
        end
        else if (kind < 80)
        begin
            n = $urandom_range(3, 1);
            repeat (n)
                queue_op(OP_READ, $urandom_range(255), $urandom_range(255), read_index());
        end
        else if (kind < 83)
            queue_op(OP_CLEAR, $urandom_range(255), $urandom_range(255), $urandom_range(2047));
        else
        begin
            // noise: any opcode and any field values
            queue_op(opcode_t'($urandom_range(3)), $urandom_range(255), $urandom_range(255),
                     $urandom_range(2047));
        end
    endtask

    task automatic queue_random(int count);
        int target;
        target = queued_ops + count;
        while (queued_ops < target)
            queue_random_chunk();
    endtask

    task automatic wait_drained();
        while (op_backlog.size() != 0 || req_valid || expected_replies.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        console_op_t nxt;
        console_op_t taken;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && request.ready)
            begin
                taken.op    = opcode_t'(req_opcode);
                taken.ch    = req_char;
                taken.color = req_color;
                taken.idx   = req_index;
                expected_replies.push_back(console_apply(taken));
            end
            if (!req_valid || request.ready)
            begin
                if (op_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    nxt = op_backlog.pop_front();
                    req_valid  <= 1'b1;
                    req_opcode <= nxt.op;
                    req_char   <= nxt.ch;
                    req_color  <= nxt.color;
                    req_index  <= nxt.idx;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin : check_responses
        console_reply_t want;
        if (!rst_n)
        begin
            resp_ready <= 1'b0;
        end
        else
        begin
            if (response.valid && resp_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("response beat with nothing expected: cursor_pos %0d",
                           response.cursor_pos);
                    mismatches++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (response.cursor_pos !== want.cursor_pos)
                    begin
                        $error("cursor_pos: expected %0d, got %0d",
                               want.cursor_pos, response.cursor_pos);
                        mismatches++;
                    end
                    if (response.read_char !== want.read_char)
                    begin
                        $error("read_char: expected 0x%02h, got 0x%02h",
                               want.read_char, response.read_char);
                        mismatches++;
                    end
                    if (response.read_color !== want.read_color)
                    begin
                        $error("read_color: expected 0x%02h, got 0x%02h",
                               want.read_color, response.read_color);
                        mismatches++;
                    end
                end
            end
            if (hold_served != hold_requests)
            begin
                hold_served <= hold_requests;
                hold_cnt    <= 400;
                resp_ready  <= 1'b0;
            end
            else if (hold_cnt != 0)
            begin
                hold_cnt   <= hold_cnt - 1;
                resp_ready <= 1'b0;
            end
            else
            begin
                resp_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    initial
    begin
        #150ms;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        blank_screen();
        cursor_col = 0;
        cursor_row = 0;
        wait (rst_n);
        @(negedge clk);

        // blank store after reset, bounds of the read index
        queue_op(OP_READ, 0, 0, 0);
        queue_op(OP_READ, 0, 0, CELL_COUNT - 1);
        queue_op(OP_READ, 0, 0, CELL_COUNT);
        queue_op(OP_READ, 8'hFF, 8'hFF, 2047);
        // spare opcode changes nothing
        queue_op(OP_SPARE, 8'hFF, 8'hFF, 2047);
        // byte extremes, then a newline mid-row
        queue_op(OP_PUT, 8'h00, 8'h00, 0);
        queue_op(OP_PUT, 8'hFF, 8'hFF, 2047);
        queue_op(OP_PUT, NEWLINE_CODE, 8'h5A, 0);
        queue_op(OP_PUT, 8'h41, 8'h1E, 0);
        queue_op(OP_READ, 0, 0, 0);
        queue_op(OP_READ, 0, 0, 1);
        queue_op(OP_READ, 0, 0, 2);
        queue_op(OP_READ, 0, 0, COLUMNS);
        // clear, then newline from column 0
        queue_op(OP_CLEAR, 8'hFF, 8'hFF, 2047);
        queue_op(OP_READ, 0, 0, 0);
        queue_op(OP_READ, 0, 0, COLUMNS);
        queue_op(OP_PUT, NEWLINE_CODE, 8'h00, 0);
        queue_op(OP_PUT, 8'h7E, 8'hA5, 0);
        queue_op(OP_READ, 0, 0, COLUMNS);
        queue_op(OP_READ, 0, 0, 0);

        queue_random(150);
        wait_drained();

        src_idle_pct  = 83;
        sink_idle_pct = 33;
        queue_random(150);
        wait_drained();

        // no idling; long receiver hold-off backs the block up
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_requests = hold_requests + 1;
        queue_random(150);
        wait_drained();

        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
